/* hdl/dtvg_pkg.sv */
// Package for the detection temporal vote gate.
// Holds the register map, status codes, word and control structs.
// No dependencies; every other file of the block imports it.
package dtvg_pkg;

	// Default sizes handed down from the top level
	localparam int WINDOW_FRAMES_DEF = 8;
	localparam int CLASS_COUNT_DEF   = 8;

	// Configuration port geometry: eight 64-bit registers at 8-byte strides
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_MIN_AREA        = 3'd0;
	localparam reg_idx_t REG_LANDSCAPE_MIN   = 3'd1;
	localparam reg_idx_t REG_LANDSCAPE_MAX   = 3'd2;
	localparam reg_idx_t REG_PORTRAIT_MIN    = 3'd3;
	localparam reg_idx_t REG_PORTRAIT_MAX    = 3'd4;
	localparam reg_idx_t REG_MATCH_REQUIRED  = 3'd5;
	localparam reg_idx_t REG_THRESHOLDS_LOW  = 3'd6;
	localparam reg_idx_t REG_THRESHOLDS_HIGH = 3'd7;

	// Register reset values
	localparam logic [15:0] MIN_AREA_RST       = 16'd5243;
	localparam logic [9:0]  LANDSCAPE_MIN_RST  = 10'd346;
	localparam logic [9:0]  LANDSCAPE_MAX_RST  = 10'd653;
	localparam logic [9:0]  PORTRAIT_MIN_RST   = 10'd97;
	localparam logic [9:0]  PORTRAIT_MAX_RST   = 10'd184;
	localparam logic [3:0]  MATCH_REQUIRED_RST = 4'd3;
	localparam logic [63:0] THRESHOLDS_RST     = 64'h8000_8000_8000_8000;

	// Result status codes
	localparam logic [1:0] ST_NONE      = 2'd0;
	localparam logic [1:0] ST_GUIDE     = 2'd1;
	localparam logic [1:0] ST_CONFIRMED = 2'd2;

	typedef struct packed {
		logic [15:0] min_area;
		logic [9:0]  landscape_min;
		logic [9:0]  landscape_max;
		logic [9:0]  portrait_min;
		logic [9:0]  portrait_max;
		logic [3:0]  match_required;
		logic [63:0] thresholds_low;
		logic [63:0] thresholds_high;
	} cfg_t;

	typedef struct packed {
		logic        present;
		logic        frame_last;
		logic [3:0]  obj_class;
		logic [15:0] confidence;
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  confirmed_class;
		logic [15:0] out_confidence;
		logic [15:0] out_box_x;
		logic [15:0] out_box_y;
		logic [15:0] out_box_w;
		logic [15:0] out_box_h;
	} out_word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic compute;
		logic check;
		logic write_hist;
		logic scan_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic frame_last;
		logic scan_done;
		logic emit_ok;
	} sts_t;

endpackage

/* hdl/dtvg_regs.sv */
// Configuration register file of the detection temporal vote gate.
// APB-style write and read access to the eight gate and vote registers.
// Depends on dtvg_pkg.
module dtvg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dtvg_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dtvg_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dtvg_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output dtvg_pkg::cfg_t                   cfg
);
	import dtvg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_area        <= MIN_AREA_RST;
			cfg_q.landscape_min   <= LANDSCAPE_MIN_RST;
			cfg_q.landscape_max   <= LANDSCAPE_MAX_RST;
			cfg_q.portrait_min    <= PORTRAIT_MIN_RST;
			cfg_q.portrait_max    <= PORTRAIT_MAX_RST;
			cfg_q.match_required  <= MATCH_REQUIRED_RST;
			cfg_q.thresholds_low  <= THRESHOLDS_RST;
			cfg_q.thresholds_high <= THRESHOLDS_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_AREA:        cfg_q.min_area        <= pwdata[15:0];
				REG_LANDSCAPE_MIN:   cfg_q.landscape_min   <= pwdata[9:0];
				REG_LANDSCAPE_MAX:   cfg_q.landscape_max   <= pwdata[9:0];
				REG_PORTRAIT_MIN:    cfg_q.portrait_min    <= pwdata[9:0];
				REG_PORTRAIT_MAX:    cfg_q.portrait_max    <= pwdata[9:0];
				REG_MATCH_REQUIRED:  cfg_q.match_required  <= pwdata[3:0];
				REG_THRESHOLDS_LOW:  cfg_q.thresholds_low  <= pwdata;
				REG_THRESHOLDS_HIGH: cfg_q.thresholds_high <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux, zero-extended to the bus
	always_comb begin
		case (idx)
			REG_MIN_AREA:        prdata = CFG_DATA_W'(cfg_q.min_area);
			REG_LANDSCAPE_MIN:   prdata = CFG_DATA_W'(cfg_q.landscape_min);
			REG_LANDSCAPE_MAX:   prdata = CFG_DATA_W'(cfg_q.landscape_max);
			REG_PORTRAIT_MIN:    prdata = CFG_DATA_W'(cfg_q.portrait_min);
			REG_PORTRAIT_MAX:    prdata = CFG_DATA_W'(cfg_q.portrait_max);
			REG_MATCH_REQUIRED:  prdata = CFG_DATA_W'(cfg_q.match_required);
			REG_THRESHOLDS_LOW:  prdata = cfg_q.thresholds_low;
			REG_THRESHOLDS_HIGH: prdata = cfg_q.thresholds_high;
			default:             prdata = '0;
		endcase
	end

endmodule

/* hdl/dtvg_ctrl.sv */
// Controller of the detection temporal vote gate.
// Sequences gate, history write, vote scan and result hand-off.
// Depends on dtvg_pkg.
module dtvg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           det_valid,
	output logic           det_stall,
	input  dtvg_pkg::sts_t sts,
	output dtvg_pkg::cmd_t cmd
);
	import dtvg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_WRITE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t state_q;

	// Take a word only when no item is in flight
	assign det_stall = (state_q != S_IDLE);

	// Decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.load_item  = (state_q == S_IDLE) && det_valid;
		cmd.compute    = (state_q == S_MUL);
		cmd.check      = (state_q == S_CHECK);
		cmd.write_hist = (state_q == S_WRITE);
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.emit       = (state_q == S_EMIT) && sts.emit_ok;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (det_valid) state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= sts.frame_last ? S_WRITE : S_IDLE;
				end
				S_WRITE: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.emit_ok) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/dtvg_dp.sv */
// Datapath of the detection temporal vote gate.
// Gate products and compares, frame best, history ring, vote counters, result register.
// Depends on dtvg_pkg.
module dtvg_dp #(
	parameter int WINDOW_FRAMES = dtvg_pkg::WINDOW_FRAMES_DEF,
	parameter int CLASS_COUNT   = dtvg_pkg::CLASS_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtvg_pkg::cfg_t      cfg,
	input  dtvg_pkg::in_word_t  det,
	input  dtvg_pkg::cmd_t      cmd,
	output dtvg_pkg::sts_t      sts,
	output logic                res_valid,
	input  logic                res_stall,
	output dtvg_pkg::out_word_t res
);
	import dtvg_pkg::*;

	localparam int PTR_W  = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
	localparam int VOTE_W = $clog2(WINDOW_FRAMES + 1);
	localparam int CMP_W  = (VOTE_W > 4) ? VOTE_W : 4;
	localparam logic [PTR_W-1:0] PTR_LAST    = PTR_W'(WINDOW_FRAMES - 1);
	localparam logic [3:0]       CLASS_LIMIT = 4'(CLASS_COUNT);

	in_word_t    item_q;
	logic [31:0] area_q;
	logic [25:0] lmin_q, lmax_q, pmin_q, pmax_q;
	logic        conf_ok_q;

	logic        best_found_q;
	logic [2:0]  best_class_q;
	logic [15:0] best_conf_q;
	logic [15:0] best_x_q, best_y_q, best_w_q, best_h_q;

	logic [3:0]        hist_q [WINDOW_FRAMES];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  scan_q;
	logic [VOTE_W-1:0] votes_q [CLASS_COUNT];
	logic              any_q;

	out_word_t res_q;
	logic      res_valid_q;

	logic [63:0] thr_word;
	logic [15:0] thr;
	logic [25:0] wq;
	logic        land_ok, port_ok, geo_ok, keep;
	logic [3:0]  entry;
	logic        hit;
	logic [2:0]  hit_class;
	out_word_t   res_d;

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= det;
	end

	// Look up the class threshold
	assign thr_word = item_q.obj_class[2] ? cfg.thresholds_high : cfg.thresholds_low;
	assign thr      = thr_word[{item_q.obj_class[1:0], 4'b0000} +: 16];

	// Register the area and ratio-bound products
	always_ff @(posedge clk) begin
		if (cmd.compute) begin
			area_q    <= 32'(item_q.box_w) * 32'(item_q.box_h);
			lmin_q    <= 26'(cfg.landscape_min) * 26'(item_q.box_h);
			lmax_q    <= 26'(cfg.landscape_max) * 26'(item_q.box_h);
			pmin_q    <= 26'(cfg.portrait_min) * 26'(item_q.box_h);
			pmax_q    <= 26'(cfg.portrait_max) * 26'(item_q.box_h);
			conf_ok_q <= (item_q.obj_class < CLASS_LIMIT) && (item_q.confidence >= thr);
		end
	end

	// Compare against the bands and the running best
	assign wq      = {2'b00, item_q.box_w, 8'h00};
	assign land_ok = (wq >= lmin_q) && (wq <= lmax_q);
	assign port_ok = (wq >= pmin_q) && (wq <= pmax_q);
	assign geo_ok  = (item_q.box_w != 16'h0) && (item_q.box_h != 16'h0)
		&& (area_q >= {cfg.min_area, 16'h0000}) && (land_ok || port_ok);
	assign keep    = item_q.present && geo_ok && conf_ok_q
		&& (item_q.confidence > best_conf_q);

	// Track the frame best; drop it once the frame result is loaded into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			best_conf_q  <= '0;
		end else if (cmd.check && keep) begin
			best_found_q <= 1'b1;
			best_conf_q  <= item_q.confidence;
		end else if (cmd.emit) begin
			best_found_q <= 1'b0;
			best_conf_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check && keep) begin
			best_class_q <= item_q.obj_class[2:0];
			best_x_q     <= item_q.box_x;
			best_y_q     <= item_q.box_y;
			best_w_q     <= item_q.box_w;
			best_h_q     <= item_q.box_h;
		end
	end

	// Write the frame outcome into the history ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_FRAMES; i++) hist_q[i] <= '0;
			wp_q <= '0;
		end else if (cmd.write_hist) begin
			hist_q[wp_q] <= best_found_q ? {1'b1, best_class_q} : 4'h0;
			wp_q         <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
		end
	end

	// Walk the ring one entry a cycle and count votes per class
	assign entry = hist_q[scan_q];

	always_ff @(posedge clk) begin
		if (cmd.write_hist) begin
			scan_q <= '0;
			any_q  <= 1'b0;
			for (int c = 0; c < CLASS_COUNT; c++) votes_q[c] <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (entry[3]) begin
				any_q <= 1'b1;
				for (int c = 0; c < CLASS_COUNT; c++) begin
					if (entry[2:0] == 3'(c)) votes_q[c] <= votes_q[c] + 1'b1;
				end
			end
		end
	end

	// Pick the lowest class that meets the vote requirement
	always_comb begin
		hit       = 1'b0;
		hit_class = '0;
		for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
			if (CMP_W'(votes_q[c]) >= CMP_W'(cfg.match_required)) begin
				hit       = 1'b1;
				hit_class = 3'(c);
			end
		end
	end

	// Build the frame result
	always_comb begin
		res_d = '0;
		if (best_found_q) begin
			if (hit) begin
				res_d.status          = ST_CONFIRMED;
				res_d.confirmed_class = hit_class;
				res_d.out_confidence  = best_conf_q;
				res_d.out_box_x       = best_x_q;
				res_d.out_box_y       = best_y_q;
				res_d.out_box_w       = best_w_q;
				res_d.out_box_h       = best_h_q;
			end else begin
				res_d.status = ST_GUIDE;
			end
		end else begin
			res_d.status = any_q ? ST_GUIDE : ST_NONE;
		end
	end

	// Hold the result word until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sts.frame_last = item_q.frame_last;
	assign sts.scan_done  = (scan_q == PTR_LAST);
	assign sts.emit_ok    = !res_valid_q || !res_stall;

	// A confirmed result always carries a nonzero best confidence
	a_confirmed_conf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == ST_CONFIRMED) |-> res_q.out_confidence != 16'h0)
		else $error("confirmed result with zero confidence");

	// Without a best, the best confidence stays cleared
	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!best_found_q |-> best_conf_q == 16'h0)
		else $error("best confidence set without a best");

	// The ring pointer stays inside the window
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PTR_LAST)
		else $error("history pointer out of range");

	// A new result is loaded only when the previous one has left or is leaving
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !res_valid_q || !res_stall)
		else $error("result overwritten before it was taken");

endmodule

/* hdl/detection_temporal_vote_gate.sv */
// Detection temporal vote gate: one detection word in, one vote result per frame out.
// Each detection goes through the gate as capture, area and ratio products, then
// compares; the word that ends a frame goes on to the history write, the vote scan
// that reads one ring entry per cycle and any wait for the result register to drain.
// A detection is kept when its area, its width/height ratio band and its class
// threshold all pass; the strictly highest confidence kept wins the frame. Registers
// sit at byte address 8*index on the 64-bit config port and should be written only
// while the block is idle.
// Depends on dtvg_pkg, dtvg_regs, dtvg_ctrl and dtvg_dp.
module detection_temporal_vote_gate #(
	parameter int WINDOW_FRAMES = dtvg_pkg::WINDOW_FRAMES_DEF,
	parameter int CLASS_COUNT   = dtvg_pkg::CLASS_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             det_valid,
	output logic                             det_stall,
	input  dtvg_pkg::in_word_t               det,
	output logic                             res_valid,
	input  logic                             res_stall,
	output dtvg_pkg::out_word_t              res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dtvg_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [dtvg_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [dtvg_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import dtvg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Configuration registers
	dtvg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	dtvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_stall (det_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Gate, history and vote datapath
	dtvg_dp #(
		.WINDOW_FRAMES (WINDOW_FRAMES),
		.CLASS_COUNT   (CLASS_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.det       (det),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
